/* sv/twda_pkg.sv */
package twda_pkg;

  // Lane accumulator and result width, and activation width
  localparam int unsigned SumW = 19;
  localparam int unsigned ActW = 8;

  // Number of lanes that own weight bits in the weight byte, and result fields
  localparam int unsigned CodeLanes = 4;
  localparam int unsigned OutFields = 4;
  localparam int unsigned CodeW     = 2;
  localparam int unsigned WeightW   = CodeLanes * CodeW;

  // Default lane count
  localparam int unsigned DefaultLanes = 4;

  // Ternary weight codes; the two remaining codes both mean zero
  localparam logic [CodeW-1:0] WCodePlus  = 2'b01;
  localparam logic [CodeW-1:0] WCodeMinus = 2'b10;

  typedef logic signed [SumW-1:0] sum_t;
  typedef logic signed [ActW-1:0] act_t;

  // Per-transaction control shared by all lanes
  typedef struct packed {
    logic en;
    logic first;
  } lane_ctrl_t;

  // Control into the result stage
  typedef struct packed {
    logic capture;
    logic stall;
  } out_ctrl_t;

endpackage

/* sv/twda_lane.sv */
module twda_lane (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  twda_pkg::lane_ctrl_t        ctrl_i,
  input  logic [twda_pkg::CodeW-1:0]  code_i,
  input  twda_pkg::act_t              act_i,
  output twda_pkg::sum_t              sum_next_o
);

  twda_pkg::sum_t sum_q, sum_d;
  twda_pkg::sum_t act_ext;
  twda_pkg::sum_t term;
  twda_pkg::sum_t base;

  // Decode the ternary weight into an add, subtract or nothing
  always_comb begin
    act_ext = twda_pkg::sum_t'(act_i);
    unique case (code_i)
      twda_pkg::WCodePlus:  term = act_ext;
      twda_pkg::WCodeMinus: term = -act_ext;
      default:              term = '0;
    endcase
    base  = ctrl_i.first ? '0 : sum_q;
    sum_d = base + term;
  end

  assign sum_next_o = sum_d;

  // Advance the accumulator on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctrl_i.en) begin
      sum_q <= sum_d;
    end
  end

  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_i.en |=> $stable(sum_q))
    else $error("lane sum moved without a transaction");

endmodule

/* sv/twda_merge.sv */
module twda_merge #(
  parameter int unsigned Lanes = twda_pkg::DefaultLanes
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  twda_pkg::out_ctrl_t  ctrl_i,
  input  twda_pkg::sum_t       lane_sum_i [Lanes],
  output logic                 out_valid_o,
  output twda_pkg::sum_t       result_o [twda_pkg::OutFields]
);

  twda_pkg::sum_t res_d [twda_pkg::OutFields];
  twda_pkg::sum_t res_q [twda_pkg::OutFields];
  logic           out_valid_q, out_valid_d;

  // Gather lane sums into the result fields; missing lanes read as zero
  for (genvar g = 0; g < twda_pkg::OutFields; g++) begin : g_field
    if (g < Lanes) begin : g_live
      assign res_d[g] = lane_sum_i[g];
    end else begin : g_absent
      assign res_d[g] = '0;
    end
  end

  // Load the result register on capture, drop valid once it is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_i.capture) begin
      out_valid_d = 1'b1;
    end else if (!ctrl_i.stall) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.capture |-> !(out_valid_q && ctrl_i.stall))
    else $error("result overwritten while still pending");

  a_capture_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.capture |=> out_valid_q)
    else $error("captured result not presented");

  a_taken_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !ctrl_i.stall && !ctrl_i.capture) |=> !out_valid_q)
    else $error("result repeated after being taken");

endmodule

/* sv/ternary_weight_dot_accumulator.sv */
// Channel | Direction | Handshake               | Payload
// input   | in        | in_valid_i / in_stall_o | first_item_i, weight_code_i, activation_i,
//         |           |                         | last_item_i
// output  | out       | out_valid_o/out_stall_i | sum_lane0_o .. sum_lane3_o
//
// One transaction per cycle while the input is not stalled: every lane does one add or subtract per cycle.
// A result appears in the output register in the cycle after its last item is accepted.
// Input stalls only for a last item while the output register holds an untaken
// result; other items keep flowing during output stalls.
// Reset clears all lane sums and the output valid.
module ternary_weight_dot_accumulator #(
  parameter int unsigned Lanes = twda_pkg::DefaultLanes
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            first_item_i,
  input  logic [twda_pkg::WeightW-1:0]    weight_code_i,
  input  logic signed [twda_pkg::ActW-1:0] activation_i,
  input  logic                            last_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [twda_pkg::SumW-1:0] sum_lane0_o,
  output logic signed [twda_pkg::SumW-1:0] sum_lane1_o,
  output logic signed [twda_pkg::SumW-1:0] sum_lane2_o,
  output logic signed [twda_pkg::SumW-1:0] sum_lane3_o
);

  logic                 in_accept;
  twda_pkg::lane_ctrl_t lane_ctrl;
  twda_pkg::out_ctrl_t  out_ctrl;
  twda_pkg::sum_t       lane_next [Lanes];
  twda_pkg::sum_t       result [twda_pkg::OutFields];

  // Hold a last item only while the pending result cannot move
  assign in_stall_o = out_valid_o && out_stall_i && last_item_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign lane_ctrl.en    = in_accept;
  assign lane_ctrl.first = first_item_i;

  assign out_ctrl.capture = in_accept && last_item_i;
  assign out_ctrl.stall   = out_stall_i;

  // Lanes beyond the weight byte see a zero weight
  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    logic [twda_pkg::CodeW-1:0] code;
    if (g < twda_pkg::CodeLanes) begin : g_coded
      assign code = weight_code_i[twda_pkg::CodeW*g +: twda_pkg::CodeW];
    end else begin : g_uncoded
      assign code = '0;
    end

    twda_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (lane_ctrl),
      .code_i     (code),
      .act_i      (activation_i),
      .sum_next_o (lane_next[g])
    );
  end

  twda_merge #(
    .Lanes (Lanes)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (out_ctrl),
    .lane_sum_i  (lane_next),
    .out_valid_o (out_valid_o),
    .result_o    (result)
  );

  assign sum_lane0_o = result[0];
  assign sum_lane1_o = result[1];
  assign sum_lane2_o = result[2];
  assign sum_lane3_o = result[3];

  a_stall_needs_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && last_item_i))
    else $error("input stalled with no pending result");

endmodule
